// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the resize size calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, idle while reset is held.
`define PARS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication built on the check above.
`define PARS_IMPLIES(lbl, ante, cons, msg) \
    `PARS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication built on the check above.
`define PARS_LEADS(lbl, ante, cons, msg) \
    `PARS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/pars_pkg.sv -----
// Types, constants and helpers shared by the resize size calculator.
package pars_pkg;

    // Width of the shared arithmetic datapath; holds the widest numerator.
    localparam int DW         = 42;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = DW;
    localparam int SQRT_STEPS = DW / 2;
    localparam int QW         = 38;
    localparam int FFN_W      = 24;
    localparam int TB_W       = 9;
    localparam int OUT_W      = 16;
    localparam int REG_W      = 26;
    localparam int LIM_W      = 22;
    localparam logic [LIM_W-1:0] ASPECT_LIMIT = LIM_W'(200);

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SIDE,
        ST_FRAMES,
        ST_ASPECT
    } t_status;

    typedef enum logic [1:0] {
        REG_ALIGN,
        REG_TIME,
        REG_MIN,
        REG_MAX
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK,
        S_RT, S_MT, S_RH, S_MH, S_RW, S_MW,
        S_V1, S_V2, S_FF, S_FN, S_DEC,
        S_QH, S_QW,
        S_NH, S_DH, S_SH, S_FH,
        S_NW, S_DW, S_SW, S_FW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_nz;
    } t_alu_rsp;

    // Clamp a datapath value to the output field range.
    function automatic logic [OUT_W-1:0] sat_out(input logic [DW-1:0] v);
        logic [OUT_W-1:0] res;
        if (v > DW'({OUT_W{1'b1}})) begin
            res = {OUT_W{1'b1}};
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/pars_alu.sv -----
// Shared bit-serial multiply, restoring divide and integer square root unit.
module pars_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pars_pkg::t_alu_req   i_req,
    input  logic [pars_pkg::DW-1:0] i_a,
    input  logic [pars_pkg::DW-1:0] i_b,
    output pars_pkg::t_alu_rsp   o_rsp,
    output logic [pars_pkg::DW-1:0] o_y
);
    import pars_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_op              r_op, n_op;
    logic [DW-1:0]    r_x, n_x;
    logic [DW-1:0]    r_y, n_y;
    logic [DW-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // One bit of product, quotient or root per cycle.
    always_comb begin
        logic [DW:0]   v_t;
        logic [DW-1:0] v_s;
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        v_t    = {r_acc, r_x[DW-1]};
        v_s    = r_x + r_y;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            case (i_req.op)
                OP_DIV: begin
                    n_x   = i_a;
                    n_y   = i_b;
                    n_acc = '0;
                    n_cnt = CNT_W'(DIV_STEPS);
                end
                OP_SQRT: begin
                    n_x   = '0;
                    n_y   = DW'(1) << (DW - 2);
                    n_acc = i_a;
                    n_cnt = CNT_W'(SQRT_STEPS);
                end
                default: begin
                    n_x   = i_a;
                    n_y   = i_b;
                    n_acc = '0;
                    n_cnt = '0;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_DIV: begin
                    if (v_t >= {1'b0, r_y}) begin
                        n_acc = DW'(v_t - {1'b0, r_y});
                        n_x   = {r_x[DW-2:0], 1'b1};
                    end else begin
                        n_acc = v_t[DW-1:0];
                        n_x   = {r_x[DW-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                OP_SQRT: begin
                    if (r_acc >= v_s) begin
                        n_acc = r_acc - v_s;
                        n_x   = (r_x >> 1) + r_y;
                    end else begin
                        n_x   = r_x >> 1;
                    end
                    n_y   = r_y >> 2;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    // Shift-add multiply, finished once the multiplier runs out of ones.
                    if (r_y == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        if (r_y[0]) begin
                            n_acc = r_acc + r_x;
                        end
                        n_x = r_x << 1;
                        n_y = r_y >> 1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.rem_nz = (r_acc != '0);
    assign o_y          = (r_op == OP_MUL) ? r_acc : r_x;

endmodule

// ----- rtl/patch_aligned_resize_size.sv -----
// Top level of the patch-aligned resize size calculator.
// A rejected item goes from the input check straight to its result, and an item that keeps its
// rounded size skips the steps that shrink or grow it.
// One item at a time; the next item can be taken in the cycle after the result is handed over. The
// shared bit-serial unit does each multiply, divide and square root in turn.
// Synchronous active-low reset restores the register defaults and idles the control.
`include "assert_macros.svh"
module patch_aligned_resize_size (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_addr,
    input  logic [25:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // frames[7:0], in_height[21:8], in_width[35:22]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // out_height[15:0], out_width[31:16]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);
    import pars_pkg::*;

    // Configuration registers.
    logic [7:0]       r_align;
    logic [4:0]       r_time;
    logic [REG_W-1:0] r_min;
    logic [REG_W-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= 8'd28;
            r_time  <= 5'd2;
            r_min   <= REG_W'(3136);
            r_max   <= REG_W'(1003520);
        end else if (i_cfg_wen) begin
            unique case (t_reg'(i_cfg_addr))
                REG_ALIGN: r_align <= i_cfg_wdata[7:0];
                REG_TIME:  r_time  <= i_cfg_wdata[4:0];
                REG_MIN:   r_min   <= i_cfg_wdata;
                REG_MAX:   r_max   <= i_cfg_wdata;
                default:   r_align <= r_align;
            endcase
        end
    end

    // A zero step acts as one.
    logic [7:0] w_f;
    logic [4:0] w_t;
    assign w_f = (r_align == 8'd0) ? 8'd1 : r_align;
    assign w_t = (r_time == 5'd0) ? 5'd1 : r_time;

    t_state            r_state, n_state;
    logic              r_started, n_started;
    logic [7:0]        r_n, n_n;
    logic [13:0]       r_h, n_h;
    logic [13:0]       r_w, n_w;
    t_status           r_status, n_status;
    logic [TB_W-1:0]   r_tb, n_tb;
    logic [OUT_W-1:0]  r_hb, n_hb;
    logic [OUT_W-1:0]  r_wb, n_wb;
    logic [DW-1:0]     r_vol, n_vol;
    logic [DW-1:0]     r_tmp, n_tmp;
    logic [FFN_W-1:0]  r_ffn, n_ffn;
    logic [QW-1:0]     r_qh, n_qh;
    logic [QW-1:0]     r_qw, n_qw;
    logic              r_grow, n_grow;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_h, n_out_h;
    logic [OUT_W-1:0]  r_out_w, n_out_w;
    t_status           r_out_st, n_out_st;

    t_alu_req          w_req;
    t_alu_rsp          w_rsp;
    logic [DW-1:0]     w_a, w_b, w_y;
    logic              w_accept;
    logic              w_step;
    logic              w_out_free;
    t_status           w_chk;
    logic [REG_W-1:0]  w_bound;

    pars_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_y     (w_y)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_bound         = r_grow ? r_min : r_max;
    assign w_step          = r_started && w_rsp.done;

    // Input checks: side, then frames, then aspect ratio.
    always_comb begin
        logic [13:0]      v_lo, v_hi;
        logic [LIM_W-1:0] v_lim;
        v_lo  = (r_h < r_w) ? r_h : r_w;
        v_hi  = (r_h < r_w) ? r_w : r_h;
        v_lim = ASPECT_LIMIT * LIM_W'(v_lo);
        if ((r_h < 14'(w_f)) || (r_w < 14'(w_f))) begin
            w_chk = ST_SIDE;
        end else if (r_n < 8'(w_t)) begin
            w_chk = ST_FRAMES;
        end else if (LIM_W'(v_hi) > v_lim) begin
            w_chk = ST_ASPECT;
        end else begin
            w_chk = ST_OK;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CHK;
            S_CHK:  n_state = (w_chk == ST_OK) ? S_RT : S_DONE;
            S_RT:   if (w_step) n_state = S_MT;
            S_MT:   if (w_step) n_state = S_RH;
            S_RH:   if (w_step) n_state = S_MH;
            S_MH:   if (w_step) n_state = S_RW;
            S_RW:   if (w_step) n_state = S_MW;
            S_MW:   if (w_step) n_state = S_V1;
            S_V1:   if (w_step) n_state = S_V2;
            S_V2:   if (w_step) n_state = S_FF;
            S_FF:   if (w_step) n_state = S_FN;
            S_FN:   if (w_step) n_state = S_DEC;
            S_DEC: begin
                if ((r_vol > DW'(r_max)) || (r_vol < DW'(r_min))) begin
                    n_state = S_QH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QH:   if (w_step) n_state = S_QW;
            S_QW:   if (w_step) n_state = S_NH;
            S_NH:   if (w_step) n_state = S_DH;
            S_DH:   if (w_step) n_state = S_SH;
            S_SH:   if (w_step) n_state = S_FH;
            S_FH:   if (w_step) n_state = S_NW;
            S_NW:   if (w_step) n_state = S_DW;
            S_DW:   if (w_step) n_state = S_SW;
            S_SW:   if (w_step) n_state = S_FW;
            S_FW:   if (w_step) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Operation and operands for the shared unit in each step.
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_a         = '0;
        w_b         = '0;
        unique case (r_state)
            S_RT: begin
                w_req.op = OP_DIV;
                w_a = DW'({r_n, 1'b0}) + DW'(w_t);
                w_b = DW'({w_t, 1'b0});
            end
            S_MT: begin w_a = r_tmp; w_b = DW'(w_t); end
            S_RH: begin
                w_req.op = OP_DIV;
                w_a = DW'({r_h, 1'b0}) + DW'(w_f);
                w_b = DW'({w_f, 1'b0});
            end
            S_MH: begin w_a = r_tmp; w_b = DW'(w_f); end
            S_RW: begin
                w_req.op = OP_DIV;
                w_a = DW'({r_w, 1'b0}) + DW'(w_f);
                w_b = DW'({w_f, 1'b0});
            end
            S_MW: begin w_a = r_tmp; w_b = DW'(w_f); end
            S_V1: begin w_a = DW'(r_tb); w_b = DW'(r_hb); end
            S_V2: begin w_a = r_tmp; w_b = DW'(r_wb); end
            S_FF: begin w_a = DW'(w_f); w_b = DW'(w_f); end
            S_FN: begin w_a = r_tmp; w_b = DW'(r_n); end
            S_QH: begin w_a = DW'(r_ffn); w_b = DW'(r_w); end
            S_QW: begin w_a = DW'(r_ffn); w_b = DW'(r_h); end
            S_NH: begin w_a = DW'(r_h); w_b = DW'(w_bound); end
            S_DH: begin w_req.op = OP_DIV; w_a = r_tmp; w_b = DW'(r_qh); end
            S_SH: begin w_req.op = OP_SQRT; w_a = r_tmp; end
            S_FH: begin w_a = r_tmp; w_b = DW'(w_f); end
            S_NW: begin w_a = DW'(r_w); w_b = DW'(w_bound); end
            S_DW: begin w_req.op = OP_DIV; w_a = r_tmp; w_b = DW'(r_qw); end
            S_SW: begin w_req.op = OP_SQRT; w_a = r_tmp; end
            S_FW: begin w_a = r_tmp; w_b = DW'(w_f); end
            default: w_req.op = OP_MUL;
        endcase
        if (r_state != S_IDLE && r_state != S_CHK && r_state != S_DEC
                && r_state != S_DONE) begin
            w_req.start = !r_started;
        end
    end

    // Datapath registers and result capture.
    always_comb begin
        n_started   = r_started;
        n_n         = r_n;
        n_h         = r_h;
        n_w         = r_w;
        n_status    = r_status;
        n_tb        = r_tb;
        n_hb        = r_hb;
        n_wb        = r_wb;
        n_vol       = r_vol;
        n_tmp       = r_tmp;
        n_ffn       = r_ffn;
        n_qh        = r_qh;
        n_qw        = r_qw;
        n_grow      = r_grow;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_h     = r_out_h;
        n_out_w     = r_out_w;
        n_out_st    = r_out_st;
        if (w_req.start) begin
            n_started = 1'b1;
        end
        if (w_step) begin
            n_started = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_n = i_s_axis_tdata[7:0];
                    n_h = i_s_axis_tdata[21:8];
                    n_w = i_s_axis_tdata[35:22];
                end
            end
            S_CHK: begin
                n_status = w_chk;
                n_hb     = '0;
                n_wb     = '0;
            end
            S_RT, S_RH, S_RW, S_V1, S_FF, S_DH: if (w_step) n_tmp = w_y;
            S_MT: if (w_step) n_tb = w_y[TB_W-1:0];
            S_MH, S_FH: if (w_step) n_hb = sat_out(w_y);
            S_MW, S_FW: if (w_step) n_wb = sat_out(w_y);
            S_V2: if (w_step) n_vol = w_y;
            S_FN: if (w_step) n_ffn = w_y[FFN_W-1:0];
            S_DEC: n_grow = !(r_vol > DW'(r_max));
            S_QH: if (w_step) n_qh = w_y[QW-1:0];
            S_QW: if (w_step) n_qw = w_y[QW-1:0];
            // Grow path rounds the quotient up.
            S_NH: if (w_step) n_tmp = w_y + (r_grow ? DW'(r_qh) - DW'(1) : '0);
            S_NW: if (w_step) n_tmp = w_y + (r_grow ? DW'(r_qw) - DW'(1) : '0);
            S_DW: if (w_step) n_tmp = w_y;
            // Grow path takes the ceiling root.
            S_SH, S_SW: begin
                if (w_step) n_tmp = w_y + DW'(r_grow && w_rsp.rem_nz);
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_h     = r_hb;
                    n_out_w     = r_wb;
                    n_out_st    = r_status;
                end
            end
            default: n_started = n_started;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
        r_n      <= n_n;
        r_h      <= n_h;
        r_w      <= n_w;
        r_status <= n_status;
        r_tb     <= n_tb;
        r_hb     <= n_hb;
        r_wb     <= n_wb;
        r_vol    <= n_vol;
        r_tmp    <= n_tmp;
        r_ffn    <= n_ffn;
        r_qh     <= n_qh;
        r_qw     <= n_qw;
        r_grow   <= n_grow;
        r_out_h  <= n_out_h;
        r_out_w  <= n_out_w;
        r_out_st <= n_out_st;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_w, r_out_h};
    assign o_m_axis_tuser  = r_out_st;

    // A rejected item carries zero sizes.
    `PARS_IMPLIES(a_err_zero, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tdata == '0, "error item with nonzero size")
    // The shared unit is quiet whenever a new item comes in.
    `PARS_IMPLIES(a_alu_idle, w_accept, !w_rsp.busy, "item accepted while arithmetic unit busy")
    // An accepted item is checked in the next cycle.
    `PARS_LEADS(a_chk_next, w_accept, r_state == S_CHK, "accepted item skipped the input check")

endmodule

// ----- tb/size_checker.sv -----
// Checker for the resize size calculator: it tracks the registers, predicts each result and compares.
module size_checker
    import pars_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_addr,
    input  logic [25:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // frames[7:0], in_height[21:8], in_width[35:22]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // out_height[15:0], out_width[31:16]
    input  logic [1:0]  i_m_axis_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status     status;
        logic [15:0] height;
        logic [15:0] width;
    } t_size;

    // Shadow copy of the configuration registers.
    logic [7:0]  align_q;
    logic [4:0]  time_q;
    logic [25:0] min_q;
    logic [25:0] max_q;

    t_size sizes_due[$];

    // Floor of the square root by bit-wise trial.
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 24; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp16(input longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Target size for one request under the current registers.
    function automatic t_size predict_size(input logic [7:0] n8, input logic [13:0] h14,
                                           input logic [13:0] w14);
        t_size s;
        longint unsigned n, h, w, f, t, lo, hi, tb, hb, wb, ff, qh, qw, r;
        n = n8;
        h = h14;
        w = w14;
        f = (align_q == 0) ? 1 : align_q;
        t = (time_q == 0) ? 1 : time_q;
        s = '{status: ST_OK, height: 16'd0, width: 16'd0};
        lo = (h < w) ? h : w;
        hi = (h < w) ? w : h;
        if (h < f || w < f) begin
            s.status = ST_SIDE;
        end else if (n < t) begin
            s.status = ST_FRAMES;
        end else if (hi > 200 * lo) begin
            s.status = ST_ASPECT;
        end else begin
            tb = ((2 * n + t) / (2 * t)) * t;
            hb = ((2 * h + f) / (2 * f)) * f;
            wb = ((2 * w + f) / (2 * f)) * f;
            ff = f * f;
            qh = ff * n * w;
            qw = ff * n * h;
            if (tb * hb * wb > max_q) begin
                hb = root_floor((h * max_q) / qh) * f;
                wb = root_floor((w * max_q) / qw) * f;
            end else if (tb * hb * wb < min_q) begin
                // Ceiling quotient, then ceiling root.
                r = root_floor((h * min_q + qh - 1) / qh);
                if (r * r < (h * min_q + qh - 1) / qh) r++;
                hb = r * f;
                r = root_floor((w * min_q + qw - 1) / qw);
                if (r * r < (w * min_q + qw - 1) / qw) r++;
                wb = r * f;
            end
            s.height = clamp16(hb);
            s.width  = clamp16(wb);
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle time %0t: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = sizes_due.size();

    // Follow register writes, predict on each accepted item, compare each result.
    always @(posedge i_clk) begin
        t_size want;
        if (!i_rst_n) begin
            align_q <= 8'd28;
            time_q  <= 5'd2;
            min_q   <= 26'd3136;
            max_q   <= 26'd1003520;
            sizes_due.delete();
        end else begin
            if (i_cfg_wen) begin
                case (t_reg'(i_cfg_addr))
                    REG_ALIGN: align_q <= i_cfg_wdata[7:0];
                    REG_TIME:  time_q  <= i_cfg_wdata[4:0];
                    REG_MIN:   min_q   <= i_cfg_wdata;
                    REG_MAX:   max_q   <= i_cfg_wdata;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                sizes_due.push_back(predict_size(i_s_axis_tdata[7:0], i_s_axis_tdata[21:8],
                                                 i_s_axis_tdata[35:22]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (sizes_due.size() == 0) begin
                    report_mismatch("unexpected result, count", 1, 0);
                end else begin
                    want = sizes_due.pop_front();
                    if (i_m_axis_tuser !== want.status)
                        report_mismatch("status", i_m_axis_tuser, want.status);
                    if (i_m_axis_tdata[15:0] !== want.height)
                        report_mismatch("out_height", i_m_axis_tdata[15:0], want.height);
                    if (i_m_axis_tdata[31:16] !== want.width)
                        report_mismatch("out_width", i_m_axis_tdata[31:16], want.width);
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the resize size calculator: stimulus, stalls and the verdict.
module tb_top;
    import pars_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [25:0] i_cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_data = '0;     // frames[7:0], in_height[21:8], in_width[35:22]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;          // out_height[15:0], out_width[31:16]
    logic [1:0]  m_user;          // status[1:0]
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;

    // Mirror of what was written, used to shape well-formed requests.
    int          cur_align = 28;
    int          cur_time = 2;

    always #2 i_clk = ~i_clk;

    patch_aligned_resize_size dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    size_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_valid), .i_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .i_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .i_m_axis_tdata(m_data), .i_m_axis_tuser(m_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("patch_aligned_resize_size test failed");
            $finish;
        end
    end

    // Receiver: a long hold-off when requested, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input t_reg idx, input logic [25:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        @(negedge i_clk);
        if (idx == REG_ALIGN) cur_align = (value[7:0] == 0) ? 1 : value[7:0];
        if (idx == REG_TIME)  cur_time  = (value[4:0] == 0) ? 1 : value[4:0];
    endtask

    // Offer one item and hold it until accepted; called at a falling edge.
    task automatic send_item(input int n, input int h, input int w);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, w[13:0], h[13:0], n[7:0]};
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    // Mostly well-formed requests, many of them small, the rest raw noise.
    task automatic send_random(input int count);
        int n, h, w, top;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99, 0) < 20) begin
                n = $urandom_range(255, 0);
                h = $urandom_range(16383, 0);
                w = $urandom_range(16383, 0);
            end else begin
                n = $urandom_range(255, cur_time);
                top = ($urandom_range(1, 0) == 1) ? 16383 : cur_align * 8;
                if (top > 16383) top = 16383;
                w = $urandom_range(top, cur_align);
                top = (200 * w < top) ? 200 * w : top;
                h = $urandom_range(top, cur_align);
            end
            send_item(n, h, w);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 23 : 0;
        recv_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 23 : 0;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests under the reset registers; the receiver first holds off
        // for a long stretch so the block fills up and stalls its input.
        hold_left = 3000;
        send_item(0, 0, 0);             // side below factor
        send_item(1, 28, 28);           // too few frames
        send_item(2, 27, 100);          // side just below factor
        send_item(0, 16383, 28);        // side passes, frame test first
        send_item(2, 28, 5601);         // aspect just over
        send_item(2, 5601, 28);
        send_item(2, 28, 5600);         // aspect exactly at limit
        send_item(255, 16383, 16383);   // shrink
        send_item(2, 28, 28);           // grow
        send_item(3, 100, 150);
        send_random(40);
        drain();

        // Zero factors count as one; zero upper bound shrinks to nothing.
        write_reg(REG_ALIGN, 26'd0);
        write_reg(REG_TIME, 26'd0);
        write_reg(REG_MAX, 26'd0);
        write_reg(REG_MIN, 26'd0);
        send_item(0, 1, 1);
        send_item(1, 1, 1);
        send_item(255, 16383, 16383);
        send_random(140);
        drain();

        // Largest bounds: growth that saturates the output.
        write_reg(REG_ALIGN, 26'd1);
        write_reg(REG_TIME, 26'd1);
        write_reg(REG_MIN, 26'h3FFFFFF);
        write_reg(REG_MAX, 26'h3FFFFFF);
        set_idling(1);
        send_item(1, 200, 1);
        send_item(1, 1, 200);
        send_item(1, 1, 1);
        send_item(255, 16383, 16383);
        send_random(140);
        drain();

        // Widest alignment factor.
        write_reg(REG_ALIGN, 26'd255);
        write_reg(REG_TIME, 26'd16);
        write_reg(REG_MIN, 26'd5000000);
        write_reg(REG_MAX, 26'd40000000);
        set_idling(2);
        send_item(15, 300, 300);
        send_item(16, 254, 300);
        send_item(255, 16383, 16383);
        send_item(16, 255, 255);
        send_random(140);
        drain();

        // Random register settings with each idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_ALIGN, 26'($urandom_range(64, 1)));
            write_reg(REG_TIME, 26'($urandom_range(16, 1)));
            write_reg(REG_MIN, 26'($urandom_range(26'h3FFFFFF, 0) >> $urandom_range(8, 0)));
            write_reg(REG_MAX, 26'($urandom_range(26'h3FFFFFF, 0) >> $urandom_range(6, 0)));
            set_idling((ph + 3) % 4);
            send_random(110);
            drain();
        end

        repeat (500) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("patch_aligned_resize_size test passed");
        end else begin
            $display("patch_aligned_resize_size test failed");
        end
        $finish;
    end

endmodule

// ----- patch_aligned_resize_size.f -----
+incdir+rtl
rtl/pars_pkg.sv
rtl/pars_alu.sv
rtl/patch_aligned_resize_size.sv
tb/size_checker.sv
tb/tb_top.sv
